// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/tte_pkg.sv =====
package tte_pkg;

    // field widths fixed by the interface
    localparam int COUNT_W   = 4;
    localparam int TEMPO_W   = 20;
    localparam int TIMEOUT_W = 16;
    localparam int STAMP_W   = 32;

    // tempo scaling: 60000 ms per minute, times 100 for hundredths
    localparam logic [63:0] TEMPO_SCALE = 64'd6000000;
    localparam logic [TEMPO_W-1:0] TEMPO_MAX = '1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

    // command codes
    localparam logic CMD_TAP   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

endpackage

// ===== hw/rtl/tte_ram.sv =====
module tte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/tap_tempo_estimator.sv =====
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_stall      i_command, i_timestamp_ms
// out       output     o_out_valid / i_out_stall    o_tap_count, o_bpm_hundredths, o_bpm_new
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_timeout_ms
//
// a clear goes straight to the done state, a tap that leaves fewer than two stamps
// passes through the check, and a tap that yields a tempo runs check, span, divide,
// saturate and done; the restoring divider yields one quotient bit per cycle.
// the stamp ring lives in one ram with a registered read, read twice per tap.
// synchronous active-low reset empties the window, zeroes the tempo and
// restores the timeout; a stalled result waits in the output register.
module tap_tempo_estimator #(
    parameter int MAX_TAPS   = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [tte_pkg::STAMP_W-1:0]     i_timestamp_ms,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tte_pkg::COUNT_W-1:0]     o_tap_count,
    output logic [tte_pkg::TEMPO_W-1:0]     o_bpm_hundredths,
    output logic                            o_bpm_new,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tte_pkg::TIMEOUT_W-1:0]   i_cfg_timeout_ms
);

    localparam int SLOT_W = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int NUM_W  = $clog2(tte_pkg::TEMPO_SCALE * 64'(MAX_TAPS - 1) + 64'd1);
    localparam int REM_W  = (NUM_W + 1 > TIME_WIDTH) ? NUM_W + 1 : TIME_WIDTH;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_TAPS - 1);
    localparam logic [SLOT_W:0]   SLOT_SPAN = (SLOT_W + 1)'(MAX_TAPS);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_TAPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SPAN,
        S_DIVIDE,
        S_SATURATE,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [SLOT_W-1:0]             r_write_slot;
    logic [CNT_W-1:0]              r_held;
    logic [tte_pkg::TEMPO_W-1:0]   r_tempo;
    logic [tte_pkg::TIMEOUT_W-1:0] r_timeout;
    logic                          r_fresh;
    logic [TIME_WIDTH-1:0]         r_now;
    logic [TIME_WIDTH-1:0]         r_span;
    logic [NUM_W-1:0]              r_num;
    logic [NUM_W-1:0]              r_quo;
    logic [REM_W-1:0]              r_rem;
    logic [DIV_CNT_W-1:0]          r_div_cnt;
    logic                          r_out_valid;
    logic [tte_pkg::COUNT_W-1:0]   r_out_count;
    logic [tte_pkg::TEMPO_W-1:0]   r_out_bpm;
    logic                          r_out_new;

    logic                  in_xfer;
    logic                  out_free;
    logic [TIME_WIDTH-1:0] rd_data;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [SLOT_W-1:0]     prev_slot;
    logic [SLOT_W-1:0]     next_slot;
    logic [SLOT_W-1:0]     oldest_slot;
    logic [SLOT_W:0]       oldest_sum;
    logic [SLOT_W:0]       back_ext;
    logic [TIME_WIDTH-1:0] gap;
    logic                  expired;
    logic [CNT_W-1:0]      held_eff;
    logic [CNT_W-1:0]      n_held;
    logic [REM_W-1:0]      rem_shift;
    logic [REM_W:0]        trial;
    logic                  fits;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ring slot arithmetic
    assign prev_slot = (r_write_slot == '0) ? SLOT_LAST : r_write_slot - 1'b1;
    assign next_slot = (r_write_slot == SLOT_LAST) ? '0 : r_write_slot + 1'b1;

    // window after the timeout check and the new stamp
    assign gap      = r_now - rd_data;
    assign expired  = (r_held != '0) && (gap > TIME_WIDTH'(r_timeout));
    assign held_eff = expired ? '0 : r_held;
    assign n_held   = (held_eff < CNT_FULL) ? held_eff + 1'b1 : held_eff;

    // oldest stamp sits n_held - 1 slots behind the one being written
    assign back_ext    = (SLOT_W + 1)'(n_held - 1'b1);
    assign oldest_sum  = {1'b0, r_write_slot} + SLOT_SPAN - back_ext;
    assign oldest_slot = (oldest_sum >= SLOT_SPAN) ? SLOT_W'(oldest_sum - SLOT_SPAN)
                                                   : oldest_sum[SLOT_W-1:0];

    // read newest stamp on acceptance, oldest stamp while checking
    assign rd_addr = (r_state == S_CHECK) ? oldest_slot : prev_slot;
    assign wr_en   = (r_state == S_CHECK);

    tte_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (MAX_TAPS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_write_slot),
        .i_wr_data (r_now),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // restoring divider step; a zero span gives an all-ones quotient
    assign rem_shift = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign trial     = {1'b0, rem_shift} - {1'b0, REM_W'(r_span)};
    assign fits      = !trial[REM_W];

    // sequencer, window state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_write_slot <= '0;
            r_held       <= '0;
            r_tempo      <= '0;
            r_timeout    <= tte_pkg::TIMEOUT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_timeout_ms;
            end
            // result register: load when an item finishes, drop on transfer
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_now <= TIME_WIDTH'(i_timestamp_ms);
                        if (i_command == tte_pkg::CMD_CLEAR) begin
                            r_held       <= '0;
                            r_write_slot <= '0;
                            r_tempo      <= '0;
                            r_fresh      <= 1'b0;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_held       <= n_held;
                    r_write_slot <= next_slot;
                    if (n_held >= CNT_W'(2)) begin
                        r_state <= S_SPAN;
                    end else begin
                        r_fresh <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_SPAN: begin
                    r_span    <= r_now - rd_data;
                    r_num     <= NUM_W'(tte_pkg::TEMPO_SCALE * 64'(r_held - 1'b1));
                    r_rem     <= '0;
                    r_div_cnt <= '0;
                    r_state   <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    r_rem     <= fits ? trial[REM_W-1:0] : rem_shift;
                    r_quo     <= {r_quo[NUM_W-2:0], fits};
                    r_num     <= r_num << 1;
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                        r_state <= S_SATURATE;
                    end
                end
                S_SATURATE: begin
                    r_tempo <= (r_quo > NUM_W'(tte_pkg::TEMPO_MAX)) ? tte_pkg::TEMPO_MAX
                                                                     : tte_pkg::TEMPO_W'(r_quo);
                    r_fresh <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_count <= tte_pkg::COUNT_W'(r_held);
                        r_out_bpm   <= r_tempo;
                        r_out_new   <= r_fresh;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tap_count      = r_out_count;
    assign o_bpm_hundredths = r_out_bpm;
    assign o_bpm_new        = r_out_new;

endmodule

// ===== hw/rtl/tte_checker.sv =====
`include "assert_macros.svh"

module tte_checker #(
    parameter int MAX_TAPS = 8
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [tte_pkg::COUNT_W-1:0]   o_tap_count,
    input logic [tte_pkg::TEMPO_W-1:0]   o_bpm_hundredths,
    input logic                          o_bpm_new
);

    localparam logic WIDE = (MAX_TAPS > 15);

    logic out_held;
    logic in_taken;
    logic fresh_out;
    logic count_two;
    logic empty_out;
    logic tempo_clear;

    assign out_held    = o_out_valid && i_out_stall;
    assign in_taken    = i_in_valid && !o_in_stall;
    assign fresh_out   = o_out_valid && o_bpm_new && !WIDE;
    assign count_two   = (o_tap_count >= tte_pkg::COUNT_W'(2));
    assign empty_out   = o_out_valid && (o_tap_count == '0) && !WIDE;
    assign tempo_clear = (o_bpm_hundredths == '0) && !o_bpm_new;

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid, "result dropped in stall")

    // each accepted transfer leaves the block busy, so inputs are not taken back to back
    `ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, in_taken, o_in_stall, "input taken back to back")

    // a fresh tempo needs at least two stamps in the window
    `ASSERT_IMPLY(a_new_count, i_clk, i_rst_n, fresh_out, count_two, "short window tempo")

    // an empty window only follows a clear, which zeroes the tempo
    `ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, empty_out, tempo_clear, "tempo after clear")

endmodule

bind tap_tempo_estimator tte_checker #(.MAX_TAPS(MAX_TAPS)) u_checker (.*);
